// ===== rtl/tcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsm_pkg
// shared types, state codes, flag bits and config register indices of the tcp connection core
// ----------------------------------------------------------------------------
package tcsm_pkg;

    localparam logic [3:0] ST_CLOSED   = 4'd0;
    localparam logic [3:0] ST_LISTEN   = 4'd1;
    localparam logic [3:0] ST_SYN_SENT = 4'd2;
    localparam logic [3:0] ST_SYN_RCVD = 4'd3;
    localparam logic [3:0] ST_ESTAB    = 4'd4;
    localparam logic [3:0] ST_FINW1    = 4'd5;
    localparam logic [3:0] ST_FINW2    = 4'd6;
    localparam logic [3:0] ST_CLOSEW   = 4'd7;
    localparam logic [3:0] ST_CLOSING  = 4'd8;
    localparam logic [3:0] ST_LASTACK  = 4'd9;
    localparam logic [3:0] ST_TIMEW    = 4'd10;

    localparam int FB_FIN = 0;
    localparam int FB_SYN = 1;
    localparam int FB_RST = 2;
    localparam int FB_ACK = 3;

    localparam logic [3:0] FL_NONE = 4'd0;
    localparam logic [3:0] FL_FIN  = 4'd1;
    localparam logic [3:0] FL_SYN  = 4'd2;
    localparam logic [3:0] FL_RST  = 4'd4;
    localparam logic [3:0] FL_ACK  = 4'd8;

    localparam logic [1:0] CFG_ISS    = 2'd0;
    localparam logic [1:0] CFG_RWIN   = 2'd1;
    localparam logic [1:0] CFG_ACTIVE = 2'd2;

    typedef struct packed {
        logic        action;
        logic [3:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] win;
        logic [15:0] len;
    } t_seg;

    typedef struct packed {
        logic [3:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [3:0]  state;
        logic [15:0] deliver;
        logic        notice;
        logic        released;
    } t_res;

    typedef struct packed {
        logic [3:0]  state;
        logic [31:0] snd_una;
        logic [31:0] snd_nxt;
        logic [31:0] rcv_nxt;
        logic [15:0] rcv_wnd;
        logic [31:0] irs;
        logic [15:0] snd_wnd;
        logic [31:0] wl1;
        logic [31:0] wl2;
        logic [31:0] fin_seq;
    } t_tcb;

    typedef struct packed {
        logic [31:0] iss;
        logic [15:0] rwin;
        logic        active;
    } t_cfg;

endpackage

// ===== rtl/tcp_connection_state_machine_core.sv =====
// ----------------------------------------------------------------------------
// tcp_connection_state_machine_core
// one tcp connection: segment arrival and close request handling
// the result of an accepted word is registered in the output register, or in the skid register while the output stalls
// throughput: one word per cycle while the skid register is empty, set by the single control block update
// the output register is skidded so input flows while a result waits
// reset and any write to the iss, rwin or active register reload the control block from configuration
// ----------------------------------------------------------------------------
module tcp_connection_state_machine_core import tcsm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // seg_flags, seg_sequence, seg_acknowledge,
                                        // seg_window, payload_length, zero pad
    input  logic         s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // reply_flags, reply_sequence,
                                        // reply_acknowledge, connection_state,
                                        // deliver_length, close_notice,
                                        // connection_released, zero pad
    output logic [7:0]   m_axis_tuser
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    t_tcb r_tcb;
    t_tcb n_tcb;
    t_tcb w_open;
    t_seg w_seg;
    t_res w_res;
    t_res r_out;
    t_res r_skid;
    logic r_out_v;
    logic r_skid_v;
    logic w_acc;

    assign w_seg.action = s_axis_tuser;
    assign w_seg.flags = s_axis_tdata[3:0];
    assign w_seg.seq = s_axis_tdata[35:4];
    assign w_seg.ack = s_axis_tdata[67:36];
    assign w_seg.win = s_axis_tdata[83:68];
    assign w_seg.len = s_axis_tdata[99:84];

    assign s_axis_tready = !r_skid_v;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ISS:    n_cfg.iss = i_cfg_data;
                CFG_RWIN:   n_cfg.rwin = i_cfg_data[15:0];
                CFG_ACTIVE: n_cfg.active = i_cfg_data[0];
                default:    n_cfg = r_cfg;
            endcase
        end
        w_open = '0;
        w_open.state = n_cfg.active ? ST_SYN_SENT : ST_LISTEN;
        w_open.snd_una = n_cfg.iss;
        w_open.snd_nxt = n_cfg.iss + {31'd0, n_cfg.active};
        w_open.rcv_wnd = n_cfg.rwin;
    end

    tcsm_next u_next (
        .i_seg (w_seg),
        .i_tcb (r_tcb),
        .i_cfg (r_cfg),
        .o_tcb (n_tcb),
        .o_res (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iss <= 32'd0;
            r_cfg.rwin <= 16'hffff;
            r_cfg.active <= 1'b0;
            r_tcb <= '0;
            r_tcb.state <= ST_LISTEN;
            r_tcb.rcv_wnd <= 16'hffff;
            r_out_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
            if (i_cfg_we && i_cfg_index <= CFG_ACTIVE) begin
                r_tcb <= w_open;
            end else if (w_acc) begin
                r_tcb <= n_tcb;
            end
            if (!r_out_v || m_axis_tready) begin
                if (r_skid_v) begin
                    r_out <= r_skid;
                    r_out_v <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out <= w_res;
                    r_out_v <= w_acc;
                end
            end else if (w_acc) begin
                r_skid <= w_res;
                r_skid_v <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = {6'd0, r_out.released, r_out.notice, r_out.deliver,
        r_out.state, r_out.ack, r_out.seq, r_out.flags};
    assign m_axis_tuser = 8'd0;

    a_skid_only_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v) && !$past(m_axis_tready))
        else $error("skid filled without a stall");
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a word with empty output register");
    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !m_axis_tready |=> r_skid_v && $stable(r_skid))
        else $error("skid word changed while stalled");

endmodule

// ===== rtl/tcsm_next.sv =====
// ----------------------------------------------------------------------------
// tcsm_next
// combinational segment-arrival and close-request logic: next control block and result word
// ----------------------------------------------------------------------------
module tcsm_next import tcsm_pkg::*; (
    input  t_seg i_seg,
    input  t_tcb i_tcb,
    input  t_cfg i_cfg,
    output t_tcb o_tcb,
    output t_res o_res
);

    logic [3:0]  st;
    logic [3:0]  fl;
    logic [31:0] lim;
    logic [31:0] seg_end;
    logic        inwin;
    logic        ack_ok;
    logic        acceptable;
    logic        fin_ok;
    logic [3:0]  cur;
    logic [3:0]  rf;
    logic [31:0] rs;
    logic [31:0] ra;
    t_tcb        n;
    logic [15:0] dlv;
    logic        ntc;
    logic        rel;
    logic        stop;

    assign st = i_tcb.state;
    assign fl = i_seg.flags;
    assign lim = i_tcb.rcv_nxt + {16'd0, i_tcb.rcv_wnd};
    assign seg_end = i_seg.seq + {16'd0, i_seg.len} - 32'd1;
    assign ack_ok = (i_seg.ack <= i_tcb.snd_nxt) && (i_seg.ack > i_tcb.snd_una);
    assign fin_ok = (i_tcb.fin_seq != 32'd0) && (i_seg.ack >= i_tcb.fin_seq);

    always_comb begin
        if (i_seg.len != 16'd0) begin
            inwin = (i_tcb.rcv_wnd != 16'd0) && (i_seg.seq >= i_tcb.rcv_nxt)
                && (i_seg.seq < lim) && (seg_end < lim);
        end else begin
            inwin = ((i_tcb.rcv_wnd != 16'd0) && (i_seg.seq >= i_tcb.rcv_nxt)
                && (i_seg.seq < lim))
                || ((i_tcb.rcv_wnd == 16'd0) && (i_seg.seq == i_tcb.rcv_nxt));
        end
    end

    always_comb begin
        n = i_tcb;
        rf = FL_NONE;
        rs = 32'd0;
        ra = 32'd0;
        dlv = 16'd0;
        ntc = 1'b0;
        rel = 1'b0;
        stop = 1'b0;
        acceptable = 1'b0;
        cur = st;
        if (i_seg.action) begin
            if (st == ST_LISTEN || st == ST_SYN_SENT) begin
                n.state = ST_CLOSED;
                rel = 1'b1;
            end else if (st == ST_SYN_RCVD || st == ST_ESTAB || st == ST_CLOSEW) begin
                rf = FL_FIN | FL_ACK;
                rs = i_tcb.snd_nxt;
                ra = i_tcb.rcv_nxt;
                n.snd_nxt = i_tcb.snd_nxt + 32'd1;
                n.fin_seq = i_tcb.snd_nxt + 32'd1;
                n.state = (st == ST_CLOSEW) ? ST_LASTACK : ST_FINW1;
            end
        end else if (st == ST_LISTEN) begin
            if (fl[FB_RST]) begin
                n.state = ST_CLOSED;
                rel = 1'b1;
            end else if (fl[FB_ACK]) begin
                rf = FL_RST;
                rs = i_seg.ack;
            end else if (fl[FB_SYN]) begin
                n.irs = i_seg.seq;
                n.rcv_nxt = i_seg.seq + 32'd1;
                n.state = ST_SYN_RCVD;
                n.snd_una = i_cfg.iss;
                n.snd_nxt = i_cfg.iss + 32'd1;
                rf = FL_SYN | FL_ACK;
                rs = i_cfg.iss;
                ra = i_seg.seq + 32'd1;
            end
        end else if (st == ST_SYN_SENT) begin
            if (fl[FB_ACK]) begin
                if (i_seg.ack <= i_cfg.iss || i_seg.ack > i_tcb.snd_nxt) begin
                    if (!fl[FB_RST]) begin
                        rf = FL_RST;
                        rs = i_seg.ack;
                        ra = i_tcb.rcv_nxt;
                    end
                    stop = 1'b1;
                end else begin
                    acceptable = 1'b1;
                end
            end
            if (!stop && fl[FB_RST]) begin
                if (acceptable) begin
                    n.state = ST_CLOSED;
                    rel = 1'b1;
                    ntc = 1'b1;
                end
                stop = 1'b1;
            end
            if (!stop && fl[FB_SYN]) begin
                n.irs = i_seg.seq;
                n.rcv_nxt = i_seg.seq + 32'd1;
                if (fl[FB_ACK]) n.snd_una = i_seg.ack;
                if (n.snd_una > i_cfg.iss) begin
                    n.state = ST_ESTAB;
                    if (i_seg.len != 16'd0) begin
                        dlv = i_seg.len;
                        n.rcv_nxt = n.rcv_nxt + {16'd0, i_seg.len};
                        n.rcv_wnd = (i_seg.len >= i_tcb.rcv_wnd) ? 16'd0
                            : i_tcb.rcv_wnd - i_seg.len;
                    end
                    rf = FL_ACK;
                    rs = i_tcb.snd_nxt;
                    ra = n.rcv_nxt;
                end else begin
                    n.state = ST_SYN_RCVD;
                    rf = FL_SYN | FL_ACK;
                    rs = i_cfg.iss;
                    ra = n.rcv_nxt;
                    n.snd_wnd = i_seg.win;
                    n.wl1 = i_seg.seq;
                    n.wl2 = i_seg.ack;
                end
            end
        end else if (st >= ST_SYN_RCVD && st <= ST_TIMEW) begin
            if (!inwin) begin
                if (!fl[FB_RST]) begin
                    rf = FL_ACK;
                    rs = i_tcb.snd_nxt;
                    ra = i_tcb.rcv_nxt;
                end
            end else if (fl[FB_RST]) begin
                if (st == ST_SYN_RCVD) ntc = i_cfg.active;
                else if (st == ST_ESTAB || st == ST_FINW1 || st == ST_FINW2
                    || st == ST_CLOSEW) ntc = 1'b1;
                n.state = ST_CLOSED;
                rel = 1'b1;
            end else if (fl[FB_SYN]) begin
                if (st == ST_SYN_RCVD && !i_cfg.active) begin
                    n.state = ST_CLOSED;
                end else begin
                    rf = FL_ACK;
                    rs = i_tcb.snd_nxt;
                    ra = i_tcb.rcv_nxt;
                end
            end else if (fl[FB_ACK]) begin
                if (st == ST_SYN_RCVD) begin
                    if (!ack_ok) begin
                        rf = FL_RST;
                        rs = i_seg.ack;
                        ra = i_tcb.rcv_nxt;
                        stop = 1'b1;
                    end else begin
                        n.snd_wnd = i_seg.win;
                        n.wl1 = i_seg.seq;
                        n.wl2 = i_seg.ack;
                        n.state = ST_ESTAB;
                    end
                end else if (st == ST_LASTACK) begin
                    if (fin_ok) begin
                        n.state = ST_CLOSED;
                        stop = 1'b1;
                    end
                end else if (st != ST_TIMEW) begin
                    if (i_seg.ack > i_tcb.snd_nxt) begin
                        rf = FL_ACK;
                        rs = i_tcb.snd_nxt;
                        ra = i_tcb.rcv_nxt;
                        stop = 1'b1;
                    end else begin
                        if ((ack_ok || i_seg.ack == i_tcb.snd_una) &&
                            (i_tcb.wl1 < i_seg.seq ||
                             (i_tcb.wl1 == i_seg.seq && i_tcb.wl2 <= i_seg.ack))) begin
                            n.snd_wnd = i_seg.win;
                            n.wl1 = i_seg.seq;
                            n.wl2 = i_seg.ack;
                        end
                        if (ack_ok) n.snd_una = i_seg.ack;
                        if (st == ST_FINW1 && fin_ok) n.state = ST_FINW2;
                        else if (st == ST_FINW2 && n.snd_una == i_tcb.snd_nxt) ntc = 1'b1;
                        else if (st == ST_CLOSING && fin_ok) n.state = ST_TIMEW;
                    end
                end
                if (!stop) begin
                    cur = n.state;
                    if (i_seg.len != 16'd0 && (cur == ST_ESTAB || cur == ST_FINW1
                        || cur == ST_FINW2)) begin
                        dlv = i_seg.len;
                        n.rcv_nxt = i_tcb.rcv_nxt + {16'd0, i_seg.len};
                        n.rcv_wnd = (i_seg.len >= i_tcb.rcv_wnd) ? 16'd0
                            : i_tcb.rcv_wnd - i_seg.len;
                        rf = FL_ACK;
                        rs = i_tcb.snd_nxt;
                        ra = n.rcv_nxt;
                    end
                    if (fl[FB_FIN]) begin
                        if (cur == ST_ESTAB || cur == ST_FINW1 || cur == ST_FINW2) begin
                            n.rcv_nxt = i_seg.seq + {16'd0, i_seg.len} + 32'd1;
                            ntc = 1'b1;
                            if (cur == ST_ESTAB) n.state = ST_CLOSEW;
                            else if (cur == ST_FINW1) n.state = ST_CLOSING;
                            else n.state = ST_TIMEW;
                        end
                        rf = FL_ACK;
                        rs = i_tcb.snd_nxt;
                        ra = n.rcv_nxt;
                    end
                end
            end
        end else begin
            if (!fl[FB_RST]) begin
                if (fl[FB_ACK]) begin
                    rf = FL_RST;
                    rs = i_seg.ack;
                end else begin
                    rf = FL_RST | FL_ACK;
                    ra = i_seg.seq + {16'd0, i_seg.len};
                end
            end
        end
        o_tcb = n;
        o_res.flags = rf;
        o_res.seq = (rf != FL_NONE) ? rs : 32'd0;
        o_res.ack = (rf != FL_NONE) ? ra : 32'd0;
        o_res.state = n.state;
        o_res.deliver = dlv;
        o_res.notice = ntc;
        o_res.released = rel;
    end

endmodule

// ===== dv/tcsm_checker.sv =====
// ----------------------------------------------------------------------------
// tcsm_checker
// watches the config port and both stream channels of the tcp connection
// core, predicts each result word from the accepted input words and
// compares every result field against the oldest prediction
// ----------------------------------------------------------------------------
module tcsm_checker import tcsm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [103:0] i_s_data,
    input  logic         i_s_user,
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [95:0]  i_m_data,
    output int           o_errors,
    output int           o_pending,
    output int           o_results
);

    t_cfg cfg;
    t_tcb tcb;
    t_res expected_results[$];

    function automatic logic in_window(logic [31:0] rnx, logic [15:0] win,
                                       logic [31:0] sq, logic [15:0] ln);
        logic [31:0] lim;
        logic [31:0] last;
        lim  = rnx + 32'(win);
        last = sq + 32'(ln) - 32'd1;
        if (ln != 16'd0)
            return win != 0 && sq >= rnx && sq < lim && last < lim;
        return (win != 0 && sq >= rnx && sq < lim) || (win == 0 && sq == rnx);
    endfunction

    function automatic logic fin_acked(logic [31:0] fin_seq, logic [31:0] ak);
        return fin_seq != 32'd0 && ak >= fin_seq;
    endfunction

    task automatic reopen();
        tcb.state   = cfg.active ? ST_SYN_SENT : ST_LISTEN;
        tcb.snd_una = cfg.iss;
        tcb.snd_nxt = cfg.iss + (cfg.active ? 32'd1 : 32'd0);
        tcb.rcv_nxt = '0;
        tcb.rcv_wnd = cfg.rwin;
        tcb.irs     = '0;
        tcb.snd_wnd = '0;
        tcb.wl1     = '0;
        tcb.wl2     = '0;
        tcb.fin_seq = '0;
    endtask

    task automatic segment_arrival(input t_seg sg, output t_res r);
        logic [3:0]  st;
        logic [3:0]  cur;
        logic        acc;
        logic        stop;
        logic        ack_ok;
        logic [3:0]  fl;
        st = tcb.state;
        fl = sg.flags;
        r = '0;
        if (sg.action) begin
            if (st == ST_LISTEN || st == ST_SYN_SENT) begin
                tcb.state = ST_CLOSED;
                r.released = 1'b1;
            end else if (st == ST_SYN_RCVD || st == ST_ESTAB || st == ST_CLOSEW) begin
                r.flags = FL_FIN | FL_ACK;
                r.seq = tcb.snd_nxt;
                r.ack = tcb.rcv_nxt;
                tcb.snd_nxt = tcb.snd_nxt + 32'd1;
                tcb.fin_seq = tcb.snd_nxt;
                tcb.state = (st == ST_CLOSEW) ? ST_LASTACK : ST_FINW1;
            end
        end else if (st == ST_LISTEN) begin
            if (fl[FB_RST]) begin
                tcb.state = ST_CLOSED;
                r.released = 1'b1;
            end else if (fl[FB_ACK]) begin
                r.flags = FL_RST; r.seq = sg.ack; r.ack = '0;
            end else if (fl[FB_SYN]) begin
                tcb.irs = sg.seq;
                tcb.rcv_nxt = sg.seq + 32'd1;
                tcb.state = ST_SYN_RCVD;
                tcb.snd_una = cfg.iss;
                r.flags = FL_SYN | FL_ACK; r.seq = cfg.iss; r.ack = tcb.rcv_nxt;
                tcb.snd_nxt = cfg.iss + 32'd1;
            end
        end else if (st == ST_SYN_SENT) begin
            acc = 1'b0;
            stop = 1'b0;
            if (fl[FB_ACK]) begin
                if (sg.ack <= cfg.iss || sg.ack > tcb.snd_nxt) begin
                    if (!fl[FB_RST]) begin
                        r.flags = FL_RST; r.seq = sg.ack; r.ack = tcb.rcv_nxt;
                    end
                    stop = 1'b1;
                end else begin
                    acc = 1'b1;
                end
            end
            if (!stop && fl[FB_RST]) begin
                if (acc) begin
                    tcb.state = ST_CLOSED;
                    r.released = 1'b1;
                    r.notice = 1'b1;
                end
                stop = 1'b1;
            end
            if (!stop && fl[FB_SYN]) begin
                tcb.irs = sg.seq;
                tcb.rcv_nxt = sg.seq + 32'd1;
                if (fl[FB_ACK]) tcb.snd_una = sg.ack;
                if (tcb.snd_una > cfg.iss) begin
                    tcb.state = ST_ESTAB;
                    if (sg.len != 0) begin
                        tcb.rcv_nxt = tcb.rcv_nxt + 32'(sg.len);
                        tcb.rcv_wnd = (sg.len >= tcb.rcv_wnd) ? 16'd0 : tcb.rcv_wnd - sg.len;
                        r.deliver = sg.len;
                    end
                    r.flags = FL_ACK; r.seq = tcb.snd_nxt; r.ack = tcb.rcv_nxt;
                end else begin
                    tcb.state = ST_SYN_RCVD;
                    r.flags = FL_SYN | FL_ACK; r.seq = cfg.iss; r.ack = tcb.rcv_nxt;
                    tcb.snd_wnd = sg.win;
                    tcb.wl1 = sg.seq;
                    tcb.wl2 = sg.ack;
                end
            end
        end else if (st >= ST_SYN_RCVD && st <= ST_TIMEW) begin
            if (!in_window(tcb.rcv_nxt, tcb.rcv_wnd, sg.seq, sg.len)) begin
                if (!fl[FB_RST]) begin
                    r.flags = FL_ACK; r.seq = tcb.snd_nxt; r.ack = tcb.rcv_nxt;
                end
            end else if (fl[FB_RST]) begin
                if (st == ST_SYN_RCVD) r.notice = cfg.active;
                else if (st == ST_ESTAB || st == ST_FINW1 || st == ST_FINW2 || st == ST_CLOSEW)
                    r.notice = 1'b1;
                tcb.state = ST_CLOSED;
                r.released = 1'b1;
            end else if (fl[FB_SYN]) begin
                if (st == ST_SYN_RCVD && !cfg.active) begin
                    tcb.state = ST_CLOSED;
                end else begin
                    r.flags = FL_ACK; r.seq = tcb.snd_nxt; r.ack = tcb.rcv_nxt;
                end
            end else if (fl[FB_ACK]) begin
                ack_ok = sg.ack <= tcb.snd_nxt && sg.ack > tcb.snd_una;
                stop = 1'b0;
                if (st == ST_SYN_RCVD) begin
                    if (!ack_ok) begin
                        r.flags = FL_RST; r.seq = sg.ack; r.ack = tcb.rcv_nxt;
                        stop = 1'b1;
                    end else begin
                        tcb.snd_wnd = sg.win;
                        tcb.wl1 = sg.seq;
                        tcb.wl2 = sg.ack;
                        tcb.state = ST_ESTAB;
                    end
                end else if (st == ST_LASTACK) begin
                    if (fin_acked(tcb.fin_seq, sg.ack)) begin
                        tcb.state = ST_CLOSED;
                        stop = 1'b1;
                    end
                end else if (st != ST_TIMEW) begin
                    if (sg.ack > tcb.snd_nxt) begin
                        r.flags = FL_ACK; r.seq = tcb.snd_nxt; r.ack = tcb.rcv_nxt;
                        stop = 1'b1;
                    end else begin
                        if ((ack_ok || sg.ack == tcb.snd_una) &&
                            (tcb.wl1 < sg.seq || (tcb.wl1 == sg.seq && tcb.wl2 <= sg.ack))) begin
                            tcb.snd_wnd = sg.win;
                            tcb.wl1 = sg.seq;
                            tcb.wl2 = sg.ack;
                        end
                        if (ack_ok) tcb.snd_una = sg.ack;
                        if (st == ST_FINW1 && fin_acked(tcb.fin_seq, sg.ack))
                            tcb.state = ST_FINW2;
                        else if (st == ST_FINW2 && tcb.snd_una == tcb.snd_nxt)
                            r.notice = 1'b1;
                        else if (st == ST_CLOSING && fin_acked(tcb.fin_seq, sg.ack))
                            tcb.state = ST_TIMEW;
                    end
                end
                if (!stop) begin
                    cur = tcb.state;
                    if (sg.len != 0 && (cur == ST_ESTAB || cur == ST_FINW1 || cur == ST_FINW2)) begin
                        tcb.rcv_nxt = tcb.rcv_nxt + 32'(sg.len);
                        tcb.rcv_wnd = (sg.len >= tcb.rcv_wnd) ? 16'd0 : tcb.rcv_wnd - sg.len;
                        r.deliver = sg.len;
                        r.flags = FL_ACK; r.seq = tcb.snd_nxt; r.ack = tcb.rcv_nxt;
                    end
                    if (fl[FB_FIN]) begin
                        if (cur == ST_ESTAB || cur == ST_FINW1 || cur == ST_FINW2) begin
                            tcb.rcv_nxt = sg.seq + 32'(sg.len) + 32'd1;
                            r.notice = 1'b1;
                            if (cur == ST_ESTAB) tcb.state = ST_CLOSEW;
                            else if (cur == ST_FINW1) tcb.state = ST_CLOSING;
                            else tcb.state = ST_TIMEW;
                        end
                        r.flags = FL_ACK; r.seq = tcb.snd_nxt; r.ack = tcb.rcv_nxt;
                    end
                end
            end
        end else begin
            if (!fl[FB_RST]) begin
                if (fl[FB_ACK]) begin
                    r.flags = FL_RST; r.seq = sg.ack; r.ack = '0;
                end else begin
                    r.flags = FL_RST | FL_ACK; r.seq = '0; r.ack = sg.seq + 32'(sg.len);
                end
            end
        end
        if (r.flags == FL_NONE) begin
            r.seq = '0;
            r.ack = '0;
        end
        r.state = tcb.state;
    endtask

    t_seg sg_in;
    t_res res_got;
    t_res res_exp;

    assign sg_in.action = i_s_user;
    assign sg_in.flags  = i_s_data[3:0];
    assign sg_in.seq    = i_s_data[35:4];
    assign sg_in.ack    = i_s_data[67:36];
    assign sg_in.win    = i_s_data[83:68];
    assign sg_in.len    = i_s_data[99:84];

    assign res_got.flags    = i_m_data[3:0];
    assign res_got.seq      = i_m_data[35:4];
    assign res_got.ack      = i_m_data[67:36];
    assign res_got.state    = i_m_data[71:68];
    assign res_got.deliver  = i_m_data[87:72];
    assign res_got.notice   = i_m_data[88];
    assign res_got.released = i_m_data[89];

    assign o_pending = expected_results.size();

    initial begin
        o_errors = 0;
        o_results = 0;
    end

    always @(posedge i_clk) begin
        t_res r;
        if (!i_rst_n) begin
            cfg.iss = '0;
            cfg.rwin = 16'hFFFF;
            cfg.active = 1'b0;
            reopen();
            expected_results.delete();
        end else begin
            if (i_m_valid && i_m_ready) begin
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    $error("result word with no prediction waiting");
                    o_errors <= o_errors + 1;
                end else begin
                    res_exp = expected_results.pop_front();
                    if (res_got != res_exp) begin
                        if (res_got.flags != res_exp.flags)
                            $error("reply_flags exp %0h got %0h", res_exp.flags, res_got.flags);
                        if (res_got.seq != res_exp.seq)
                            $error("reply_sequence exp %0h got %0h", res_exp.seq, res_got.seq);
                        if (res_got.ack != res_exp.ack)
                            $error("reply_acknowledge exp %0h got %0h", res_exp.ack, res_got.ack);
                        if (res_got.state != res_exp.state)
                            $error("connection_state exp %0d got %0d", res_exp.state,
                                   res_got.state);
                        if (res_got.deliver != res_exp.deliver)
                            $error("deliver_length exp %0d got %0d", res_exp.deliver,
                                   res_got.deliver);
                        if (res_got.notice != res_exp.notice)
                            $error("close_notice exp %0d got %0d", res_exp.notice,
                                   res_got.notice);
                        if (res_got.released != res_exp.released)
                            $error("connection_released exp %0d got %0d", res_exp.released,
                                   res_got.released);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ISS:    cfg.iss = i_cfg_data;
                    CFG_RWIN:   cfg.rwin = i_cfg_data[15:0];
                    CFG_ACTIVE: cfg.active = i_cfg_data[0];
                    default: ;
                endcase
                if (i_cfg_index == CFG_ISS || i_cfg_index == CFG_RWIN ||
                    i_cfg_index == CFG_ACTIVE)
                    reopen();
            end
            if (i_s_valid && i_s_ready) begin
                segment_arrival(sg_in, r);
                expected_results.push_back(r);
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives the tcp connection core with directed corner segments, then with
// random connection sessions (handshake, data, fin, close, rst and noise)
// under several back-pressure mixes; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_top;
    import tcsm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEM_TARGET    = 1600;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [7:0]   m_axis_tuser;

    int errors;
    int pending;
    int results;
    int words_sent;
    int sessions;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    tcp_connection_state_machine_core dut (.*);

    tcsm_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (s_axis_tvalid),
        .i_s_ready   (s_axis_tready),
        .i_s_data    (s_axis_tdata),
        .i_s_user    (s_axis_tuser),
        .i_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .i_m_data    (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_word(input logic act, input logic [3:0] fl, input logic [31:0] sq,
                             input logic [31:0] ak, input logic [15:0] wn,
                             input logic [15:0] ln);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {4'd0, ln, wn, ak, sq, fl};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        words_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic open_conn(input logic [31:0] iss, input logic [15:0] rwin, input logic act);
        drain();
        reg_write(CFG_ISS, iss);
        reg_write(CFG_RWIN, {16'd0, rwin});
        reg_write(CFG_ACTIVE, {31'd0, act});
    endtask

    function automatic logic [15:0] pick_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) return 16'($urandom_range(0, 64));
        if (k < 95) return 16'($urandom_range(65, 1500));
        return 16'($urandom);
    endfunction

    task automatic run_session();
        logic [31:0] iss;
        logic [31:0] peer;
        logic [31:0] mine;
        logic [15:0] rwin;
        logic [15:0] ln;
        logic        act;
        int          k;
        int          n;
        case ($urandom_range(0, 5))
            0: iss = 32'h0;
            1: iss = 32'hFFFF_FFFF;
            2: iss = 32'hFFFF_FFF0;
            default: iss = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0: rwin = 16'd0;
            1: rwin = 16'd1;
            2: rwin = 16'($urandom);
            default: rwin = 16'hFFFF;
        endcase
        peer = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF8 : $urandom;
        act = 1'($urandom_range(0, 1));
        open_conn(iss, rwin, act);
        if (act) begin
            if ($urandom_range(0, 3) == 0) begin
                send_word(1'b0, FL_SYN, peer, $urandom, 16'($urandom), 16'd0);
                send_word(1'b0, FL_ACK, peer + 1, iss + 1, 16'($urandom), 16'd0);
            end else begin
                send_word(1'b0, FL_SYN | FL_ACK, peer, iss + 1, 16'($urandom), 16'd0);
            end
        end else begin
            send_word(1'b0, FL_SYN, peer, $urandom, 16'($urandom), 16'd0);
            send_word(1'b0, FL_ACK, peer + 1, iss + 1, 16'($urandom), 16'd0);
        end
        peer = peer + 1;
        mine = iss + 1;
        n = $urandom_range(8, 30);
        repeat (n) begin
            k = $urandom_range(0, 99);
            ln = pick_len();
            if (k < 50) begin
                send_word(1'b0, FL_ACK, peer, mine, 16'($urandom), ln);
                peer = peer + 32'(ln);
            end else if (k < 60) begin
                send_word(1'b0, FL_FIN | FL_ACK, peer, mine, 16'($urandom), ln);
                peer = peer + 32'(ln) + 1;
            end else if (k < 68) begin
                send_word(1'b1, 4'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom));
                mine = mine + 1;
            end else if (k < 73) begin
                send_word(1'b0, ($urandom_range(0, 1) ? FL_RST : FL_RST | FL_ACK), peer,
                          mine, 16'($urandom), 16'd0);
            end else if (k < 78) begin
                send_word(1'b0, FL_SYN | FL_ACK, peer, mine, 16'($urandom), 16'd0);
            end else if (k < 86) begin
                send_word(1'b0, FL_ACK | 4'($urandom_range(0, 1)), peer,
                          mine + 32'($urandom_range(0, 2)) - 32'd1, 16'($urandom), 16'd0);
            end else begin
                send_word(1'($urandom), 4'($urandom), $urandom, $urandom, 16'($urandom),
                          16'($urandom));
            end
        end
        sessions++;
    endtask

    initial begin
        int wait_cycles;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_ISS;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        words_sent = 0;
        sessions = 0;
        quiet_cycles = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset state: listen corners, then the closed state
        send_word(1'b0, FL_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_word(1'b0, FL_NONE, 32'h0, 32'h0, 16'h0, 16'h0);
        send_word(1'b0, FL_RST | FL_ACK, 32'h0, 32'h0, 16'h0, 16'h0);
        send_word(1'b0, FL_NONE, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'hFFFF);
        send_word(1'b0, FL_ACK | FL_FIN, 32'h1234, 32'h5678, 16'h0, 16'd10);
        send_word(1'b0, FL_RST, 32'h1, 32'h1, 16'h1, 16'h1);
        send_word(1'b1, FL_NONE, 32'h0, 32'h0, 16'h0, 16'h0);
        // active open: bad ack, rst with good ack
        open_conn(32'h100, 16'hFFFF, 1'b1);
        send_word(1'b0, FL_ACK, 32'h0, 32'h100, 16'h0, 16'h0);
        send_word(1'b0, FL_RST, 32'h0, 32'h0, 16'h0, 16'h0);
        send_word(1'b0, FL_RST | FL_ACK, 32'h0, 32'h101, 16'h0, 16'h0);
        // passive opens with zero and then four-byte window: syn, ack, zero-window probe, fin, close
        open_conn(32'hFFFF_FFFF, 16'd0, 1'b0);
        send_word(1'b0, FL_SYN, 32'h50, 32'h0, 16'h10, 16'h0);
        send_word(1'b0, FL_SYN, 32'h51, 32'h0, 16'h10, 16'h0);
        open_conn(32'hFFFF_FFFF, 16'd4, 1'b0);
        send_word(1'b0, FL_SYN, 32'h50, 32'h0, 16'h10, 16'h0);
        send_word(1'b0, FL_ACK, 32'h51, 32'h0, 16'hFFFF, 16'h0);
        send_word(1'b0, FL_ACK, 32'h51, 32'h0, 16'hFFFF, 16'd9);
        send_word(1'b0, FL_ACK, 32'h51, 32'h0, 16'hFFFF, 16'd4);
        send_word(1'b0, FL_ACK, 32'h55, 32'h0, 16'hFFFF, 16'd0);
        send_word(1'b1, FL_NONE, 32'h0, 32'h0, 16'h0, 16'h0);
        send_word(1'b0, FL_FIN | FL_ACK, 32'h55, 32'h1, 16'h0, 16'h0);
        send_word(1'b0, FL_ACK, 32'h56, 32'h1, 16'h0, 16'h0);

        while (words_sent < ITEM_TARGET) begin
            case (sessions % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            run_session();
        end

        s_axis_tvalid = 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(negedge i_clk);
        $display("covered %0d segment and close words over %0d connection sessions,",
                 words_sent, sessions);
        $display("%0d result words checked under four back-pressure mixes", results);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
